>>> hw/rtl/ilid_pkg.sv
`timescale 1ns / 1ps

package ilid_pkg;

   // Number of list cells; the count register must be able to hold this value.
   localparam int Capacity = 16;

   localparam int ModeW  = 2;
   localparam int PosW   = 5;
   localparam int ValueW = 32;
   localparam int OutCntW = 5;

   localparam int CntW = $clog2(Capacity + 1);
   // Width in which a position and the count are compared.
   localparam int CmpW = (CntW > PosW) ? CntW : PosW;

   localparam logic [ModeW-1:0] MODE_READ   = 2'd0;
   localparam logic [ModeW-1:0] MODE_INSERT = 2'd1;
   localparam logic [ModeW-1:0] MODE_DELETE = 2'd2;

   localparam logic signed [ValueW-1:0] NOT_FOUND_VALUE = '1;

   typedef struct packed {
      logic [ModeW-1:0]         mode;
      logic [PosW-1:0]          position;
      logic signed [ValueW-1:0] item_value;
   } op_type;

   typedef struct packed {
      logic signed [ValueW-1:0] read_value;
      logic                     found;
      logic                     done_res;
      logic [OutCntW-1:0]       entry_count;
   } result_type;

endpackage

>>> hw/rtl/ilid_list.sv
`timescale 1ns / 1ps

module ilid_list (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ilid_pkg::op_type     op,
   output ilid_pkg::result_type result
);

   logic signed [ilid_pkg::ValueW-1:0] cells_ff [ilid_pkg::Capacity];
   logic signed [ilid_pkg::ValueW-1:0] cells_in [ilid_pkg::Capacity];
   logic [ilid_pkg::CntW-1:0]          count_ff;
   logic [ilid_pkg::CntW-1:0]          count_in;

   logic [ilid_pkg::CmpW-1:0] pos_ext;
   logic [ilid_pkg::CmpW-1:0] count_ext;
   logic [ilid_pkg::CmpW-1:0] count_after_ext;
   logic                      in_list;
   logic                      read_ok;
   logic                      insert_ok;
   logic                      delete_ok;
   logic signed [ilid_pkg::ValueW-1:0] read_word;

   assign pos_ext   = ilid_pkg::CmpW'(op.position);
   assign count_ext = ilid_pkg::CmpW'(count_ff);
   assign in_list   = pos_ext < count_ext;

   always_comb begin
      read_ok   = 1'b0;
      insert_ok = 1'b0;
      delete_ok = 1'b0;
      unique case (op.mode)
         ilid_pkg::MODE_READ: begin
            read_ok = in_list;
         end
         ilid_pkg::MODE_INSERT: begin
            insert_ok = (pos_ext <= count_ext) &&
                        (count_ext < ilid_pkg::CmpW'(ilid_pkg::Capacity));
         end
         ilid_pkg::MODE_DELETE: begin
            delete_ok = in_list;
         end
         default: begin
         end
      endcase
   end

   // Every cell compares its own place with the position, so an insert or a
   // delete moves the whole tail in one step.
   always_comb begin
      for (int i = 0; i < ilid_pkg::Capacity; i++) begin
         cells_in[i] = cells_ff[i];
         if (insert_ok) begin
            if (pos_ext == ilid_pkg::CmpW'(i)) begin
               cells_in[i] = op.item_value;
            end else if ((i > 0) && (pos_ext < ilid_pkg::CmpW'(i))) begin
               cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (delete_ok) begin
            if ((i < ilid_pkg::Capacity - 1) && (pos_ext <= ilid_pkg::CmpW'(i))) begin
               cells_in[i] = cells_ff[(i < ilid_pkg::Capacity - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      read_word = '0;
      for (int i = 0; i < ilid_pkg::Capacity; i++) begin
         if (pos_ext == ilid_pkg::CmpW'(i)) begin
            read_word = cells_ff[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (insert_ok) begin
         count_in = count_ff + ilid_pkg::CntW'(1);
      end else if (delete_ok) begin
         count_in = count_ff - ilid_pkg::CntW'(1);
      end
   end

   assign count_after_ext = ilid_pkg::CmpW'(count_in);

   always_comb begin
      result.read_value  = read_ok ? read_word : ilid_pkg::NOT_FOUND_VALUE;
      result.found       = read_ok;
      result.done_res    = read_ok | insert_ok | delete_ok;
      result.entry_count = count_after_ext[ilid_pkg::OutCntW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         cells_ff <= cells_in;
      end
   end

endmodule

>>> hw/rtl/indexed_list_insert_delete.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake         Word
// req      in         req_valid/stall   mode, position, item_value
// rsp      out        rsp_valid/stall   read_value, found, done_res, entry_count
//
// Each word passes an input register and then a result register, and one word is
// taken every cycle unless req is stalled.
// The list cells and the count change as a word moves into the result register.
// Reset empties the list by clearing the count; the cells are not cleared.
// A stall on rsp holds each full register; with both full, req stalls that cycle.

module indexed_list_insert_delete (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ilid_pkg::ModeW-1:0]          req_mode,
   input  logic [ilid_pkg::PosW-1:0]           req_position,
   input  logic signed [ilid_pkg::ValueW-1:0]  req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ilid_pkg::ValueW-1:0]  rsp_read_value,
   output logic                                rsp_found,
   output logic                                rsp_done_res,
   output logic [ilid_pkg::OutCntW-1:0]        rsp_entry_count
);

   logic                 op_valid_ff;
   ilid_pkg::op_type     op_ff;
   logic                 rsp_valid_ff;
   ilid_pkg::result_type result_ff;
   ilid_pkg::result_type result_in;
   logic                 advance;
   logic                 fire;
   logic                 load;

   // The result register frees up when it is empty or its word is taken.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = op_valid_ff && advance;
   assign load    = !op_valid_ff || advance;

   assign req_stall = !load;

   ilid_list u_list (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .op     (op_ff),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            op_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= op_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         op_ff.mode       <= req_mode;
         op_ff.position   <= req_position;
         op_ff.item_value <= req_item_value;
      end
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = result_ff.read_value;
   assign rsp_found       = result_ff.found;
   assign rsp_done_res    = result_ff.done_res;
   assign rsp_entry_count = result_ff.entry_count;

endmodule
